// ----- rtl/klc_pkg.sv -----
// Shared types and constants for the keyed ordered list block.
// Used by klc_ctrl, klc_dp and keyed_ordered_list_with_cursor.
package klc_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int MAX_PAYLOAD_DEF = 32;

	localparam int KEY_W   = 16;
	localparam int LEN_W   = 6;
	localparam int POS_W   = 5;
	localparam int BYTE_W  = 8;
	localparam int ACT_W   = 3;
	localparam int ST_W    = 3;
	localparam int ELIM_W  = 5;
	localparam int PLIM_W  = 6;
	localparam int CFG_W   = 6;
	localparam int TDATA_W = 40;

	localparam logic CFG_ENTRY_LIMIT   = 1'b0;
	localparam logic CFG_PAYLOAD_LIMIT = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_STAGE  = 3'd0,
		ACT_INSERT = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_FIND   = 3'd3,
		ACT_NEXT   = 3'd4,
		ACT_PREV   = 3'd5,
		ACT_CLEAR  = 3'd6,
		ACT_NOP    = 3'd7
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK          = 3'd0,
		ST_FULL        = 3'd1,
		ST_TOO_LARGE   = 3'd2,
		ST_DUPLICATE   = 3'd3,
		ST_NOT_FOUND   = 3'd4,
		ST_EMPTY       = 3'd5,
		ST_NO_NEIGHBOR = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SEARCH,
		S_ALLOC,
		S_COPY_RD,
		S_COPY_WR,
		S_STREAM_RD,
		S_STREAM_EM,
		S_REPLY
	} state_t;

	typedef struct packed {
		logic    load;
		logic    stage_wr;
		logic    search_init;
		logic    search_step;
		logic    sel_found;
		logic    unlink;
		logic    alloc_init;
		logic    alloc_step;
		logic    link;
		logic    copy_wr;
		logic    sel_nbr;
		logic    clear;
		logic    emit_plain;
		logic    emit_byte;
		status_t st;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    full;
		logic    too_large;
		logic    head_none;
		logic    sel_none;
		logic    nbr_none;
		logic    walk_end;
		logic    match;
		logic    s_end;
		logic    slot_used;
		logic    copy_done;
		logic    stream_last;
		logic    out_free;
	} sts_t;

endpackage

// ----- rtl/klc_ctrl.sv -----
// Sequencer for the keyed ordered list: decodes a request and steps the datapath.
// Depends on klc_pkg.
module klc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  klc_pkg::sts_t sts,
	output klc_pkg::cmd_t cmd
);

	klc_pkg::state_t  state_q, state_d;
	klc_pkg::status_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= klc_pkg::S_IDLE;
			st_q    <= klc_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.st   = st_q;
		state_d  = state_q;
		st_d     = st_q;
		in_ready = 1'b0;
		case (state_q)
			klc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = klc_pkg::S_DISPATCH;
				end
			end
			klc_pkg::S_DISPATCH: begin
				state_d = klc_pkg::S_REPLY;
				st_d    = klc_pkg::ST_OK;
				case (sts.act)
					klc_pkg::ACT_STAGE: cmd.stage_wr = 1'b1;
					klc_pkg::ACT_INSERT: begin
						if (sts.full) st_d = klc_pkg::ST_FULL;
						else if (sts.too_large) st_d = klc_pkg::ST_TOO_LARGE;
						else begin
							cmd.search_init = 1'b1;
							state_d = klc_pkg::S_SEARCH;
						end
					end
					klc_pkg::ACT_REMOVE, klc_pkg::ACT_FIND: begin
						if (sts.head_none) st_d = klc_pkg::ST_EMPTY;
						else begin
							cmd.search_init = 1'b1;
							state_d = klc_pkg::S_SEARCH;
						end
					end
					klc_pkg::ACT_NEXT, klc_pkg::ACT_PREV: begin
						if (sts.head_none || sts.sel_none) st_d = klc_pkg::ST_EMPTY;
						else if (sts.nbr_none) st_d = klc_pkg::ST_NO_NEIGHBOR;
						else begin
							cmd.sel_nbr = 1'b1;
							state_d = klc_pkg::S_STREAM_RD;
						end
					end
					klc_pkg::ACT_CLEAR: cmd.clear = 1'b1;
					default: ;
				endcase
			end
			klc_pkg::S_SEARCH: begin
				if (sts.walk_end) begin
					if (sts.act == klc_pkg::ACT_INSERT) begin
						cmd.alloc_init = 1'b1;
						state_d = klc_pkg::S_ALLOC;
					end else begin
						st_d    = klc_pkg::ST_NOT_FOUND;
						state_d = klc_pkg::S_REPLY;
					end
				end else if (sts.match) begin
					case (sts.act)
						klc_pkg::ACT_INSERT: begin
							cmd.sel_found = 1'b1;
							st_d    = klc_pkg::ST_DUPLICATE;
							state_d = klc_pkg::S_REPLY;
						end
						klc_pkg::ACT_REMOVE: begin
							cmd.unlink = 1'b1;
							st_d    = klc_pkg::ST_OK;
							state_d = klc_pkg::S_REPLY;
						end
						default: begin
							cmd.sel_found = 1'b1;
							state_d = klc_pkg::S_STREAM_RD;
						end
					endcase
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			klc_pkg::S_ALLOC: begin
				if (sts.s_end) begin
					st_d    = klc_pkg::ST_FULL;
					state_d = klc_pkg::S_REPLY;
				end else if (sts.slot_used) begin
					cmd.alloc_step = 1'b1;
				end else begin
					cmd.link = 1'b1;
					state_d  = klc_pkg::S_COPY_RD;
				end
			end
			klc_pkg::S_COPY_RD: begin
				if (sts.copy_done) begin
					st_d    = klc_pkg::ST_OK;
					state_d = klc_pkg::S_REPLY;
				end else begin
					state_d = klc_pkg::S_COPY_WR;
				end
			end
			klc_pkg::S_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d     = klc_pkg::S_COPY_RD;
			end
			klc_pkg::S_STREAM_RD: state_d = klc_pkg::S_STREAM_EM;
			klc_pkg::S_STREAM_EM: begin
				if (sts.out_free) begin
					cmd.emit_byte = 1'b1;
					state_d = sts.stream_last ? klc_pkg::S_IDLE : klc_pkg::S_STREAM_RD;
				end
			end
			klc_pkg::S_REPLY: begin
				if (sts.out_free) begin
					cmd.emit_plain = 1'b1;
					state_d = klc_pkg::S_IDLE;
				end
			end
			default: state_d = klc_pkg::S_IDLE;
		endcase
	end

endmodule

// ----- rtl/klc_dp.sv -----
// Datapath of the keyed ordered list: entry table, links, staging and payload
// memories, walk counters and the output register. Depends on klc_pkg.
module klc_dp #(
	parameter int CAPACITY          = klc_pkg::CAPACITY_DEF,
	parameter int MAX_PAYLOAD_BYTES = klc_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  klc_pkg::action_t             in_act,
	input  logic [klc_pkg::KEY_W-1:0]    in_key,
	input  logic [klc_pkg::LEN_W-1:0]    in_plen,
	input  logic [klc_pkg::POS_W-1:0]    in_spos,
	input  logic [klc_pkg::BYTE_W-1:0]   in_sbyte,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [klc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         out_ready,
	output logic                         out_valid,
	output klc_pkg::status_t             out_status,
	output logic [klc_pkg::KEY_W-1:0]    out_key,
	output logic [klc_pkg::LEN_W-1:0]    out_len,
	output logic [klc_pkg::POS_W-1:0]    out_pos,
	output logic [klc_pkg::BYTE_W-1:0]   out_byte,
	output logic                         out_last,
	input  klc_pkg::cmd_t                cmd,
	output klc_pkg::sts_t                sts
);

	localparam int IW    = $clog2(CAPACITY + 1);
	localparam int SW    = $clog2(CAPACITY);
	localparam int BW    = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
	localparam int DEPTH = CAPACITY * MAX_PAYLOAD_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [IW-1:0] NONE = IW'(CAPACITY);

	function automatic logic [AW-1:0] pay_addr(input logic [SW-1:0] idx,
		input logic [klc_pkg::LEN_W-1:0] off);
		pay_addr = AW'(int'(idx) * MAX_PAYLOAD_BYTES + int'(off));
	endfunction

	logic [klc_pkg::ELIM_W-1:0] entry_limit_q;
	logic [klc_pkg::PLIM_W-1:0] payload_limit_q;

	klc_pkg::action_t            act_q;
	logic [klc_pkg::KEY_W-1:0]   key_q;
	logic [klc_pkg::LEN_W-1:0]   plen_q;
	logic [klc_pkg::POS_W-1:0]   spos_q;
	logic [klc_pkg::BYTE_W-1:0]  sbyte_q;

	logic [klc_pkg::KEY_W-1:0] keys_q [CAPACITY];
	logic [klc_pkg::LEN_W-1:0] lens_q [CAPACITY];
	logic [IW-1:0]             fwd_q  [CAPACITY];
	logic [IW-1:0]             bwd_q  [CAPACITY];
	logic [CAPACITY-1:0]       in_use_q;

	logic [IW-1:0] head_q, tail_q, sel_q, count_q;
	logic [IW-1:0] p_q, steps_q, s_q;
	logic [SW-1:0] sidx_q;
	logic [klc_pkg::LEN_W-1:0] i_q;

	logic [klc_pkg::BYTE_W-1:0] stage_mem [MAX_PAYLOAD_BYTES];
	logic [klc_pkg::BYTE_W-1:0] pay_mem [DEPTH];
	logic [klc_pkg::BYTE_W-1:0] stage_rd_q, pay_rd_q;

	logic [SW-1:0] p_idx, s_idx, sel_idx, tail_idx;
	logic [IW-1:0] nbr, unl_nx, unl_pv;
	logic [klc_pkg::LEN_W-1:0] cur_len;
	logic stage_ok;

	assign p_idx    = p_q[SW-1:0];
	assign s_idx    = s_q[SW-1:0];
	assign sel_idx  = sel_q[SW-1:0];
	assign tail_idx = tail_q[SW-1:0];
	assign nbr      = (act_q == klc_pkg::ACT_NEXT) ? fwd_q[sel_idx] : bwd_q[sel_idx];
	assign unl_nx   = fwd_q[p_idx];
	assign unl_pv   = bwd_q[p_idx];
	assign cur_len  = lens_q[sidx_q];
	assign stage_ok = int'(spos_q) < MAX_PAYLOAD_BYTES;

	always_comb begin
		sts.act         = act_q;
		sts.full        = (int'(count_q) + 1 > int'(entry_limit_q)) || (int'(count_q) >= CAPACITY);
		sts.too_large   = (plen_q > payload_limit_q) || (int'(plen_q) > MAX_PAYLOAD_BYTES);
		sts.head_none   = head_q >= NONE;
		sts.sel_none    = sel_q >= NONE;
		sts.nbr_none    = nbr >= NONE;
		sts.walk_end    = (steps_q >= NONE) || (p_q >= NONE);
		sts.match       = in_use_q[p_idx] && (keys_q[p_idx] == key_q);
		sts.s_end       = s_q >= NONE;
		sts.slot_used   = in_use_q[s_idx];
		sts.copy_done   = i_q >= plen_q;
		sts.stream_last = (cur_len == '0) || (i_q + 6'd1 == cur_len);
		sts.out_free    = !out_valid || out_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_limit_q   <= 5'd16;
			payload_limit_q <= 6'd32;
			in_use_q        <= '0;
			head_q          <= NONE;
			tail_q          <= NONE;
			sel_q           <= NONE;
			count_q         <= '0;
			p_q             <= NONE;
			steps_q         <= '0;
			s_q             <= '0;
			sidx_q          <= '0;
			i_q             <= '0;
			out_valid       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					klc_pkg::CFG_ENTRY_LIMIT:   entry_limit_q <= cfg_data[klc_pkg::ELIM_W-1:0];
					klc_pkg::CFG_PAYLOAD_LIMIT: payload_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.search_init) begin
				p_q     <= head_q;
				steps_q <= '0;
			end
			if (cmd.search_step) begin
				p_q     <= fwd_q[p_idx];
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.sel_found) begin
				sel_q  <= p_q;
				sidx_q <= p_idx;
				i_q    <= '0;
			end
			if (cmd.sel_nbr) begin
				sel_q  <= nbr;
				sidx_q <= nbr[SW-1:0];
				i_q    <= '0;
			end
			if (cmd.alloc_init) begin
				s_q <= '0;
				i_q <= '0;
			end
			if (cmd.alloc_step) s_q <= s_q + 1'b1;
			if (cmd.link) begin
				in_use_q[s_idx] <= 1'b1;
				if (head_q >= NONE || tail_q >= NONE) head_q <= s_q;
				tail_q  <= s_q;
				count_q <= count_q + 1'b1;
				sel_q   <= s_q;
			end
			if (cmd.copy_wr || cmd.emit_byte) i_q <= i_q + 1'b1;
			if (cmd.unlink) begin
				if (p_q == head_q) head_q <= unl_nx;
				if (unl_nx < NONE) sel_q <= unl_nx;
				else begin
					sel_q  <= unl_pv;
					tail_q <= unl_pv;
				end
				in_use_q[p_idx] <= 1'b0;
				if (count_q != '0) count_q <= count_q - 1'b1;
			end
			if (cmd.clear) begin
				in_use_q <= '0;
				head_q   <= NONE;
				tail_q   <= NONE;
				sel_q    <= NONE;
				count_q  <= '0;
			end
			if (cmd.emit_plain || cmd.emit_byte) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// request registers, entry fields, links and output result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= in_act;
			key_q   <= in_key;
			plen_q  <= in_plen;
			spos_q  <= in_spos;
			sbyte_q <= in_sbyte;
		end
		if (cmd.link) begin
			keys_q[s_idx] <= key_q;
			lens_q[s_idx] <= plen_q;
			fwd_q[s_idx]  <= NONE;
			if (head_q >= NONE || tail_q >= NONE) bwd_q[s_idx] <= NONE;
			else begin
				fwd_q[tail_idx] <= s_q;
				bwd_q[s_idx]    <= tail_q;
			end
		end
		if (cmd.unlink) begin
			if (p_q != head_q && unl_pv < NONE) fwd_q[unl_pv[SW-1:0]] <= unl_nx;
			if (unl_nx < NONE) bwd_q[unl_nx[SW-1:0]] <= unl_pv;
		end
		if (cmd.emit_plain) begin
			out_status <= cmd.st;
			out_key    <= '0;
			out_len    <= '0;
			out_pos    <= '0;
			out_byte   <= '0;
			out_last   <= 1'b1;
		end
		if (cmd.emit_byte) begin
			out_status <= klc_pkg::ST_OK;
			out_key    <= keys_q[sidx_q];
			out_len    <= cur_len;
			out_pos    <= i_q[klc_pkg::POS_W-1:0];
			out_byte   <= (cur_len == '0) ? '0 : pay_rd_q;
			out_last   <= sts.stream_last;
		end
	end

	// staging buffer
	always_ff @(posedge clk) begin
		if (cmd.stage_wr && stage_ok) stage_mem[BW'(spos_q)] <= sbyte_q;
		stage_rd_q <= stage_mem[BW'(i_q)];
	end

	// payload store
	always_ff @(posedge clk) begin
		if (cmd.copy_wr) pay_mem[pay_addr(s_idx, i_q)] <= stage_rd_q;
		pay_rd_q <= pay_mem[pay_addr(sidx_q, i_q)];
	end

endmodule

// ----- rtl/keyed_ordered_list_with_cursor.sv -----
// Top level of the keyed ordered list with cursor.
// Depends on klc_pkg, klc_ctrl and klc_dp.
//
// Usage:
//  Requests arrive on the s_ channel: s_tuser carries the action, s_tdata the
//  key, payload length and staging position and byte. Results leave on the m_
//  channel, one per request or one per payload byte for find, next and
//  previous; m_tlast marks the final result of a request, m_tuser the status.
//  Configuration (entry limit, payload limit) is written through cfg_we,
//  cfg_index and cfg_data while the block is idle.
// Timing:
//  One request at a time. A key search walks the list one entry per cycle;
//  insert then scans for a free slot one per cycle and copies the payload
//  byte by byte, a staging read then a payload write for each byte;
//  streaming emits the payload byte by byte (read of the payload memory, then
//  load of the output register, held while that register is still full).
// Reset: arst_n empties the list, clears the cursor and loads the limits with
//  16 entries and 32 bytes. No clearing pass is needed.
// Stall: a result waits in the output register while m_tready is low; the
//  sequencer holds until the register frees up.
module keyed_ordered_list_with_cursor #(
	parameter int CAPACITY          = klc_pkg::CAPACITY_DEF,
	parameter int MAX_PAYLOAD_BYTES = klc_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// entry_key[15:0], payload_length[21:16], stage_position[26:22], stage_byte[34:27]
	input  logic [klc_pkg::TDATA_W-1:0]   s_tdata,
	// action[2:0]
	input  logic [klc_pkg::ACT_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// selected_key[15:0], selected_length[21:16], byte_position[26:22], payload_byte[34:27]
	output logic [klc_pkg::TDATA_W-1:0]   m_tdata,
	// status[2:0]
	output logic [klc_pkg::ST_W-1:0]      m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [klc_pkg::CFG_W-1:0]     cfg_data
);

	klc_pkg::cmd_t    cmd;
	klc_pkg::sts_t    sts;
	klc_pkg::status_t out_status;
	logic [klc_pkg::KEY_W-1:0]  out_key;
	logic [klc_pkg::LEN_W-1:0]  out_len;
	logic [klc_pkg::POS_W-1:0]  out_pos;
	logic [klc_pkg::BYTE_W-1:0] out_byte;

	klc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	klc_dp #(
		.CAPACITY          (CAPACITY),
		.MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_act     (klc_pkg::action_t'(s_tuser)),
		.in_key     (s_tdata[15:0]),
		.in_plen    (s_tdata[21:16]),
		.in_spos    (s_tdata[26:22]),
		.in_sbyte   (s_tdata[34:27]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (out_status),
		.out_key    (out_key),
		.out_len    (out_len),
		.out_pos    (out_pos),
		.out_byte   (out_byte),
		.out_last   (m_tlast),
		.cmd        (cmd),
		.sts        (sts)
	);

	assign m_tdata = {5'b0, out_byte, out_pos, out_len, out_key};
	assign m_tuser = out_status;

	// a result is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_plain || cmd.emit_byte) |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending result");

	// plain reply and stream byte never collide
	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_plain && cmd.emit_byte))
		else $error("two results loaded in one cycle");

	// after a request is taken the sequencer is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while previous one in work");

endmodule

// ----- sim/keyed_ordered_list_with_cursor_test.sv -----
// Testbench for keyed_ordered_list_with_cursor: random and directed requests are checked
// against an in-bench model of the keyed list, with random stalls on both streams.
// Depends on klc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module keyed_ordered_list_with_cursor_test;

	localparam int NSLOT  = 16;
	localparam int MAXPL  = 32;
	localparam int NONE   = NSLOT;
	localparam int WD_MAX = 4000;

	typedef struct {
		klc_pkg::action_t act;
		logic [15:0]      key;
		logic [5:0]       plen;
		logic [4:0]       spos;
		logic [7:0]       sbyte;
	} request_t;

	typedef struct {
		klc_pkg::status_t st;
		logic [15:0]      key;
		logic [5:0]       len;
		logic [4:0]       pos;
		logic [7:0]       byt;
		logic             tl;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [klc_pkg::TDATA_W-1:0] s_tdata = '0;
	logic [klc_pkg::ACT_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [klc_pkg::TDATA_W-1:0] m_tdata;
	logic [klc_pkg::ST_W-1:0] m_tuser;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [klc_pkg::CFG_W-1:0] cfg_data = '0;

	keyed_ordered_list_with_cursor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// queues: requests waiting for the driver, replies the list model predicts
	request_t req_q[$];
	reply_t   reply_q[$];
	int       fails = 0;
	int       tx_idle = 0;
	int       rx_idle = 0;
	logic     hold_req = 1'b0;
	logic     s_fire = 1'b0;

	// list model state
	logic [15:0] m_keys [NSLOT];
	logic [5:0]  m_lens [NSLOT];
	logic        m_used [NSLOT];
	int          m_fwd  [NSLOT];
	int          m_bwd  [NSLOT];
	logic [7:0]  m_store [NSLOT][MAXPL];
	logic [7:0]  m_stage [MAXPL];
	logic        m_staged [MAXPL];
	int          m_head, m_tail, m_sel, m_count;
	int          m_elim, m_plim;

	function automatic int find_slot(logic [15:0] key);
		int p;
		p = m_head;
		for (int n = 0; n < NSLOT && p < NSLOT; n++) begin
			if (m_used[p] && m_keys[p] == key)
				return p;
			p = m_fwd[p];
		end
		return NONE;
	endfunction

	// insert passes every check and will copy plen staged bytes
	function automatic bit insert_copies(logic [15:0] key, logic [5:0] plen);
		return !(m_count + 1 > m_elim || m_count >= NSLOT) && plen <= m_plim &&
			plen <= MAXPL && find_slot(key) == NONE;
	endfunction

	task automatic push_plain(klc_pkg::status_t st);
		reply_t r;
		r = '{st, 16'd0, 6'd0, 5'd0, 8'd0, 1'b1};
		reply_q.push_back(r);
	endtask

	task automatic push_stream(int idx);
		reply_t r;
		int len;
		len = m_lens[idx];
		if (len == 0) begin
			r = '{klc_pkg::ST_OK, m_keys[idx], 6'd0, 5'd0, 8'd0, 1'b1};
			reply_q.push_back(r);
		end else begin
			for (int i = 0; i < len; i++) begin
				r = '{klc_pkg::ST_OK, m_keys[idx], 6'(len), 5'(i), m_store[idx][i],
					i + 1 == len};
				reply_q.push_back(r);
			end
		end
	endtask

	// model one request, queue its replies
	task automatic predict_request(request_t q);
		int t, s, nx, pv;
		case (q.act)
			klc_pkg::ACT_STAGE: begin
				m_stage[q.spos] = q.sbyte;
				m_staged[q.spos] = 1'b1;
				push_plain(klc_pkg::ST_OK);
			end
			klc_pkg::ACT_INSERT: begin
				if (m_count + 1 > m_elim || m_count >= NSLOT)
					push_plain(klc_pkg::ST_FULL);
				else if (q.plen > m_plim || q.plen > MAXPL)
					push_plain(klc_pkg::ST_TOO_LARGE);
				else begin
					t = find_slot(q.key);
					if (t < NSLOT) begin
						m_sel = t;
						push_plain(klc_pkg::ST_DUPLICATE);
					end else begin
						s = 0;
						while (s < NSLOT && m_used[s])
							s++;
						m_keys[s] = q.key;
						m_lens[s] = q.plen;
						m_used[s] = 1'b1;
						for (int i = 0; i < q.plen; i++)
							m_store[s][i] = m_stage[i];
						m_fwd[s] = NONE;
						if (m_head >= NSLOT || m_tail >= NSLOT) begin
							m_head = s;
							m_bwd[s] = NONE;
						end else begin
							m_fwd[m_tail] = s;
							m_bwd[s] = m_tail;
						end
						m_tail = s;
						m_count++;
						m_sel = s;
						push_plain(klc_pkg::ST_OK);
					end
				end
			end
			klc_pkg::ACT_REMOVE: begin
				t = find_slot(q.key);
				if (m_head >= NSLOT)
					push_plain(klc_pkg::ST_EMPTY);
				else if (t >= NSLOT)
					push_plain(klc_pkg::ST_NOT_FOUND);
				else begin
					nx = m_fwd[t];
					pv = m_bwd[t];
					if (t == m_head) begin
						m_head = nx;
						if (nx < NSLOT)
							m_bwd[nx] = NONE;
					end else if (pv < NSLOT) begin
						m_fwd[pv] = nx;
					end
					if (nx < NSLOT) begin
						m_bwd[nx] = pv;
						m_sel = nx;
					end else begin
						m_sel = pv;
						m_tail = pv;
					end
					m_used[t] = 1'b0;
					if (m_count > 0)
						m_count--;
					push_plain(klc_pkg::ST_OK);
				end
			end
			klc_pkg::ACT_FIND: begin
				t = find_slot(q.key);
				if (m_head >= NSLOT)
					push_plain(klc_pkg::ST_EMPTY);
				else if (t >= NSLOT)
					push_plain(klc_pkg::ST_NOT_FOUND);
				else begin
					m_sel = t;
					push_stream(t);
				end
			end
			klc_pkg::ACT_NEXT, klc_pkg::ACT_PREV: begin
				if (m_head >= NSLOT || m_sel >= NSLOT)
					push_plain(klc_pkg::ST_EMPTY);
				else begin
					t = (q.act == klc_pkg::ACT_NEXT) ? m_fwd[m_sel] : m_bwd[m_sel];
					if (t >= NSLOT)
						push_plain(klc_pkg::ST_NO_NEIGHBOR);
					else begin
						m_sel = t;
						push_stream(t);
					end
				end
			end
			klc_pkg::ACT_CLEAR: begin
				for (int i = 0; i < NSLOT; i++)
					m_used[i] = 1'b0;
				m_head = NONE;
				m_tail = NONE;
				m_sel = NONE;
				m_count = 0;
				push_plain(klc_pkg::ST_OK);
			end
			default: push_plain(klc_pkg::ST_OK);
		endcase
	endtask

	// queue a request; an insert that would copy never-staged bytes becomes a stage
	task automatic add_request(klc_pkg::action_t act, logic [15:0] key, logic [5:0] plen,
		logic [4:0] spos, logic [7:0] sbyte);
		request_t q;
		q = '{act, key, plen, spos, sbyte};
		if (act == klc_pkg::ACT_INSERT && insert_copies(key, plen)) begin
			for (int i = 0; i < plen; i++) begin
				if (!m_staged[i]) begin
					q = '{klc_pkg::ACT_STAGE, key, plen, 5'(i), 8'($urandom)};
					break;
				end
			end
		end
		predict_request(q);
		req_q.push_back(q);
	endtask

	task automatic add_random;
		logic [15:0] kpool [8];
		int r;
		klc_pkg::action_t a;
		logic [15:0] k;
		logic [5:0] pl;
		kpool = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h0001, 16'h0002,
			16'h8000, 16'h7FFE};
		r = $urandom_range(99);
		if (r < 30)      a = klc_pkg::ACT_STAGE;
		else if (r < 56) a = klc_pkg::ACT_INSERT;
		else if (r < 66) a = klc_pkg::ACT_REMOVE;
		else if (r < 80) a = klc_pkg::ACT_FIND;
		else if (r < 88) a = klc_pkg::ACT_NEXT;
		else if (r < 96) a = klc_pkg::ACT_PREV;
		else if (r < 98) a = klc_pkg::ACT_CLEAR;
		else             a = klc_pkg::ACT_NOP;
		k = ($urandom_range(9) < 8) ? kpool[$urandom_range(7)] : 16'($urandom);
		r = $urandom_range(99);
		if (r < 70)      pl = 6'($urandom_range(4));
		else if (r < 85) pl = 6'($urandom_range(32));
		else             pl = 6'($urandom_range(63));
		add_request(a, k, pl, 5'($urandom), 8'($urandom));
	endtask

	task automatic write_cfg(logic idx, int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= klc_pkg::CFG_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == klc_pkg::CFG_ENTRY_LIMIT)
			m_elim = val & 31;
		else
			m_plim = val & 63;
	endtask

	task automatic drain;
		while (req_q.size() > 0 || reply_q.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	// request driver: new request only when the previous one was taken
	always @(posedge clk)
		s_fire <= s_tvalid && s_tready;

	always @(negedge clk) begin
		request_t q;
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (req_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
				q = req_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= q.act;
				s_tdata <= {5'd0, q.sbyte, q.spos, q.plen, q.key};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// reply side ready, with a long hold-off on request
	always @(negedge clk) begin
		static int hold_left = 0;
		static logic hold_seen = 1'b0;
		if (hold_req && !hold_seen) begin
			hold_seen = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= rx_idle);
		end
	end

	// reply monitor
	always @(posedge clk) begin
		reply_t e;
		if (m_tvalid && m_tready) begin
			if (reply_q.size() == 0) begin
				$error("unexpected reply: status %0d tdata %h", m_tuser, m_tdata);
				fails++;
			end else begin
				e = reply_q.pop_front();
				check_field("status", e.st, m_tuser);
				check_field("selected_key", e.key, m_tdata[15:0]);
				check_field("selected_length", e.len, m_tdata[21:16]);
				check_field("byte_position", e.pos, m_tdata[26:22]);
				check_field("payload_byte", e.byt, m_tdata[34:27]);
				check_field("last", e.tl, m_tlast);
			end
		end
	end

	// watchdog: cycles with no handshake on either stream
	always @(posedge clk) begin
		static int quiet = 0;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else if (++quiet >= WD_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int elims [5];
		int plims [5];
		elims = '{16, 1, 4, 2, 16};
		plims = '{32, 0, 8, 31, 32};
		for (int i = 0; i < NSLOT; i++)
			m_used[i] = 1'b0;
		for (int i = 0; i < MAXPL; i++)
			m_staged[i] = 1'b0;
		m_head = NONE;
		m_tail = NONE;
		m_sel = NONE;
		m_count = 0;
		m_elim = 16;
		m_plim = 32;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_cfg(klc_pkg::CFG_ENTRY_LIMIT, 16);
		write_cfg(klc_pkg::CFG_PAYLOAD_LIMIT, 32);
		tx_idle = 25;
		rx_idle = 68;

		// directed: field extremes, every action, every status but full
		add_request(klc_pkg::ACT_NEXT, 16'h0, 6'd0, 5'd0, 8'h00);      // empty list
		add_request(klc_pkg::ACT_FIND, 16'h1, 6'd0, 5'd0, 8'h00);      // empty list
		add_request(klc_pkg::ACT_REMOVE, 16'h1, 6'd0, 5'd0, 8'h00);    // empty list
		add_request(klc_pkg::ACT_STAGE, 16'h0, 6'd0, 5'd0, 8'h00);
		add_request(klc_pkg::ACT_STAGE, 16'h0, 6'd0, 5'd1, 8'hFF);
		add_request(klc_pkg::ACT_STAGE, 16'hFFFF, 6'd63, 5'd2, 8'hA5);
		add_request(klc_pkg::ACT_STAGE, 16'h0, 6'd0, 5'd3, 8'h5A);
		add_request(klc_pkg::ACT_STAGE, 16'h0, 6'd0, 5'd31, 8'h80);
		add_request(klc_pkg::ACT_INSERT, 16'h0000, 6'd0, 5'd0, 8'h00); // empty payload
		add_request(klc_pkg::ACT_INSERT, 16'hFFFF, 6'd4, 5'd0, 8'h00);
		add_request(klc_pkg::ACT_INSERT, 16'hFFFF, 6'd1, 5'd0, 8'h00); // duplicate
		add_request(klc_pkg::ACT_INSERT, 16'h1234, 6'd33, 5'd0, 8'h00); // too large
		add_request(klc_pkg::ACT_INSERT, 16'h1234, 6'd63, 5'd0, 8'h00);
		add_request(klc_pkg::ACT_FIND, 16'hFFFF, 6'd0, 5'd0, 8'h00);
		add_request(klc_pkg::ACT_NEXT, 16'h0, 6'd0, 5'd0, 8'h00);      // tail: no neighbor
		add_request(klc_pkg::ACT_PREV, 16'h0, 6'd0, 5'd0, 8'h00);      // empty payload
		add_request(klc_pkg::ACT_PREV, 16'h0, 6'd0, 5'd0, 8'h00);      // head: no neighbor
		add_request(klc_pkg::ACT_FIND, 16'h4321, 6'd0, 5'd0, 8'h00);   // not found
		add_request(klc_pkg::ACT_REMOVE, 16'h4321, 6'd0, 5'd0, 8'h00); // not found
		add_request(klc_pkg::ACT_REMOVE, 16'hFFFF, 6'd0, 5'd0, 8'h00); // tail: cursor back
		add_request(klc_pkg::ACT_NOP, 16'hFFFF, 6'd63, 5'd31, 8'hFF);
		add_request(klc_pkg::ACT_CLEAR, 16'h0, 6'd0, 5'd0, 8'h00);
		add_request(klc_pkg::ACT_NEXT, 16'h0, 6'd0, 5'd0, 8'h00);      // no selection
		drain();

		for (int p = 0; p < 5; p++) begin
			if (p == 2) begin
				tx_idle = 68;
				rx_idle = 25;
			end else if (p == 4) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			write_cfg(klc_pkg::CFG_ENTRY_LIMIT, elims[p]);
			write_cfg(klc_pkg::CFG_PAYLOAD_LIMIT, plims[p]);
			for (int i = 0; i < 40; i++)
				add_random();
			// long reply hold-off while requests keep coming
			if (p == 4)
				hold_req = 1'b1;
			drain();
		end

		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
